// ===== hw/rtl/pklt_pkg.sv =====
// Package for the pooled keyed list table.
// Holds the request kind codes and the packed entry payload type.
// No dependencies.
package pklt_pkg;

  typedef enum logic [2:0] {
    KIND_ADD      = 3'd0,
    KIND_REM_KEY  = 3'd1,
    KIND_REM_SLOT = 3'd2,
    KIND_LOOKUP   = 3'd3,
    KIND_NEWEST   = 3'd4
  } kind_e;

  typedef struct packed {
    logic        [31:0] key;
    logic        [31:0] length;
    logic signed [31:0] result;
    logic signed [31:0] channel;
    logic        [31:0] tick;
  } entry_t;

endpackage

// ===== hw/rtl/pklt_link_mem.sv =====
// Link memory: one next-slot link per entry, synchronous registered read.
// Per-entry valid bits give the reset chain (slot i links to i+1) until written.
// Depends on nothing.
module pklt_link_mem #(
  parameter int ENTRIES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [$clog2(ENTRIES)-1:0]         waddr_i,
  input  logic [$clog2(ENTRIES+1)-1:0]       wdata_i,
  input  logic                               re_i,
  input  logic [$clog2(ENTRIES)-1:0]         raddr_i,
  output logic [$clog2(ENTRIES+1)-1:0]       rdata_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);

  logic [LW-1:0]      mem [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  logic [LW-1:0]      rd_q;
  logic               rd_vld_q;
  logic [IW-1:0]      rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q  <= vld_q[raddr_i];
        rd_addr_q <= raddr_i;
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : (LW'(rd_addr_q) + LW'(1));

endmodule

// ===== hw/rtl/pklt_entry_mem.sv =====
// Entry payload memory: key, length, result, channel and tick per slot.
// Synchronous read, contents undefined until written.
// Depends on pklt_pkg.
module pklt_entry_mem #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  pklt_pkg::entry_t           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output pklt_pkg::entry_t           rdata_o
);

  pklt_pkg::entry_t mem [ENTRIES];
  pklt_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

// ===== hw/rtl/pooled_keyed_list_table_unit.sv =====
// Pooled keyed list table, top level: list control, head registers, output stage.
// Depends on pklt_pkg, pklt_link_mem and pklt_entry_mem.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request beat: kind, key and
//   payload. Output channel (out_valid_o/out_ready_i) returns exactly one result
//   beat per request. Requests are handled one at a time; in_ready_o is high
//   while the control is idle, even when a previous result still waits.
//   An add takes the head of the free list in ST_ADD, or goes straight to
//   ST_RESP when the pool is full. Lookup and get newest walk the active list
//   in ST_WALK; a remove by key or slot walks it and then unlinks the slot in
//   ST_UNLINK. A key or slot that is not found ends the walk at the null link,
//   and an empty list goes straight to ST_RESP. The active list is walked one
//   link per cycle through the registered read of the link memory.
//   A stalled receiver holds the result in the output register; the next
//   request is still taken and waits in its final state for that register.
//   Reset empties the active list and chains the free list 0..ENTRIES-1;
//   no clearing pass is needed, the block is ready right after reset.
module pooled_keyed_list_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic [31:0]        key_addr_i,
  input  logic [31:0]        length_i,
  input  logic signed [31:0] result_code_i,
  input  logic signed [31:0] channel_or_samples_i,
  input  logic [31:0]        tick_stamp_i,
  input  logic [3:0]         slot_sel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic [3:0]         slot_o,
  output logic [31:0]        found_addr_o,
  output logic [31:0]        found_length_o,
  output logic signed [31:0] found_result_o,
  output logic signed [31:0] found_channel_o,
  output logic [31:0]        found_tick_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ADD    = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_UNLINK = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [LW-1:0] active_head_q, active_head_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] prev_q, prev_d;

  pklt_pkg::kind_e  kind_q, kind_d, kind_in;
  logic [31:0]      key_q, key_d;
  logic [3:0]       sel_q, sel_d;
  pklt_pkg::entry_t pay_q, pay_d;

  logic             res_ok_q, res_ok_d;
  logic [3:0]       res_slot_q, res_slot_d;
  pklt_pkg::entry_t res_pay_q, res_pay_d;

  logic             out_valid_q, out_valid_d;
  logic             ok_q, ok_d;
  logic [3:0]       slot_q, slot_d;
  pklt_pkg::entry_t out_pay_q, out_pay_d;

  logic             link_we, link_re;
  logic [IW-1:0]    link_waddr;
  logic [LW-1:0]    link_wdata;
  logic [LW-1:0]    rd_addr;
  logic [LW-1:0]    link_rd;
  logic             ent_we;
  pklt_pkg::entry_t ent_rd;

  logic             accept;
  logic [LW-1:0]    start_addr;
  logic             hit;
  logic [IW+3:0]    slot_w;
  logic [LW+3:0]    cur_w, sel_w;
  logic             out_free;

  assign kind_in    = pklt_pkg::kind_e'(kind_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign start_addr = (kind_in == pklt_pkg::KIND_ADD) ? free_head_q : active_head_q;
  assign slot_w     = {4'b0, cur_q[IW-1:0]};
  assign cur_w      = {4'b0, cur_q};
  assign sel_w      = {LW'(0), sel_q};
  assign out_free   = !out_valid_q || out_ready_i;

  pklt_link_mem #(
    .ENTRIES(ENTRIES)
  ) u_link_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (link_re),
    .raddr_i(rd_addr[IW-1:0]),
    .rdata_o(link_rd)
  );

  pklt_entry_mem #(
    .ENTRIES(ENTRIES)
  ) u_entry_mem (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(cur_q[IW-1:0]),
    .wdata_i(pay_q),
    .re_i   (link_re),
    .raddr_i(rd_addr[IW-1:0]),
    .rdata_o(ent_rd)
  );

  always_comb begin
    hit = 1'b0;
    unique case (kind_q) inside
      pklt_pkg::KIND_REM_KEY, pklt_pkg::KIND_LOOKUP: hit = (ent_rd.key == key_q);
      pklt_pkg::KIND_REM_SLOT:                       hit = (cur_w == sel_w);
      pklt_pkg::KIND_NEWEST:                         hit = 1'b1;
      default:                                       hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d       = state_q;
    active_head_d = active_head_q;
    free_head_d   = free_head_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    kind_d        = kind_q;
    key_d         = key_q;
    sel_d         = sel_q;
    pay_d         = pay_q;
    res_ok_d      = res_ok_q;
    res_slot_d    = res_slot_q;
    res_pay_d     = res_pay_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    ok_d          = ok_q;
    slot_d        = slot_q;
    out_pay_d     = out_pay_q;
    link_we       = 1'b0;
    link_waddr    = cur_q[IW-1:0];
    link_wdata    = active_head_q;
    link_re       = 1'b0;
    rd_addr       = start_addr;
    ent_we        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d       = kind_in;
          key_d        = key_addr_i;
          sel_d        = slot_sel_i;
          pay_d.key     = key_addr_i;
          pay_d.length  = length_i;
          pay_d.result  = result_code_i;
          pay_d.channel = channel_or_samples_i;
          pay_d.tick    = tick_stamp_i;
          cur_d        = start_addr;
          prev_d       = NULL_LINK;
          res_ok_d     = 1'b0;
          res_slot_d   = '0;
          res_pay_d    = '0;
          link_re      = (start_addr != NULL_LINK);
          unique case (kind_in) inside
            pklt_pkg::KIND_ADD: begin
              state_d = (free_head_q == NULL_LINK) ? ST_RESP : ST_ADD;
            end
            pklt_pkg::KIND_REM_KEY, pklt_pkg::KIND_REM_SLOT,
            pklt_pkg::KIND_LOOKUP, pklt_pkg::KIND_NEWEST: begin
              state_d = (active_head_q == NULL_LINK) ? ST_RESP : ST_WALK;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_ADD: begin
        free_head_d   = link_rd;
        active_head_d = cur_q;
        link_we       = 1'b1;
        link_wdata    = active_head_q;
        ent_we        = 1'b1;
        res_ok_d      = 1'b1;
        res_slot_d    = slot_w[3:0];
        state_d       = ST_RESP;
      end
      ST_WALK: begin
        if (hit) begin
          if (kind_q == pklt_pkg::KIND_LOOKUP || kind_q == pklt_pkg::KIND_NEWEST) begin
            res_ok_d   = 1'b1;
            res_slot_d = slot_w[3:0];
            res_pay_d  = ent_rd;
            state_d    = ST_RESP;
          end else begin
            if (prev_q == NULL_LINK) begin
              active_head_d = link_rd;
            end else begin
              link_we    = 1'b1;
              link_waddr = prev_q[IW-1:0];
              link_wdata = link_rd;
            end
            state_d = ST_UNLINK;
          end
        end else if (link_rd == NULL_LINK) begin
          state_d = ST_RESP;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rd;
          rd_addr = link_rd;
          link_re = 1'b1;
        end
      end
      ST_UNLINK: begin
        link_we     = 1'b1;
        link_wdata  = free_head_q;
        free_head_d = cur_q;
        res_ok_d    = 1'b1;
        res_slot_d  = slot_w[3:0];
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ok_d        = res_ok_q;
          slot_d      = res_slot_q;
          out_pay_d   = res_pay_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      active_head_q <= NULL_LINK;
      free_head_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      active_head_q <= active_head_d;
      free_head_q   <= free_head_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    kind_q     <= kind_d;
    key_q      <= key_d;
    sel_q      <= sel_d;
    pay_q      <= pay_d;
    res_ok_q   <= res_ok_d;
    res_slot_q <= res_slot_d;
    res_pay_q  <= res_pay_d;
    ok_q       <= ok_d;
    slot_q     <= slot_d;
    out_pay_q  <= out_pay_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign slot_o          = slot_q;
  assign found_addr_o    = out_pay_q.key;
  assign found_length_o  = out_pay_q.length;
  assign found_result_o  = out_pay_q.result;
  assign found_channel_o = out_pay_q.channel;
  assign found_tick_o    = out_pay_q.tick;

  a_rise_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result beat raised outside the response state");

  a_heads_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(free_head_q == active_head_q && free_head_q != NULL_LINK))
    else $error("slot is head of both free and active lists");

  a_walk_not_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_ADD || state_q == ST_UNLINK)
      |-> cur_q != NULL_LINK)
    else $error("list operation on the null link");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> (slot_q == 4'd0 && out_pay_q == '0))
    else $error("failed result carries nonzero fields");

endmodule

// ===== bench/pklt_result_checker.sv =====
// Result checker for the pooled keyed list table: tracks free and active lists,
// predicts one result per request beat and compares each result beat in order.
// Depends on pklt_pkg.
module pklt_result_checker #(
  parameter int ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         kind_i,
  input  logic [31:0]        key_addr_i,
  input  logic [31:0]        length_i,
  input  logic signed [31:0] result_code_i,
  input  logic signed [31:0] channel_or_samples_i,
  input  logic [31:0]        tick_stamp_i,
  input  logic [3:0]         slot_sel_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               ok_i,
  input  logic [3:0]         slot_i,
  input  logic [31:0]        found_addr_i,
  input  logic [31:0]        found_length_i,
  input  logic signed [31:0] found_result_i,
  input  logic signed [31:0] found_channel_i,
  input  logic [31:0]        found_tick_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic [4:0] NIL = 5'(ENTRIES);

  typedef struct packed {
    logic             ok;
    logic [3:0]       slot;
    pklt_pkg::entry_t found;
  } table_result_t;

  pklt_pkg::entry_t pool_entry [ENTRIES];
  logic [4:0]       next_link [ENTRIES];
  logic [4:0]       active_head;
  logic [4:0]       free_head;
  table_result_t    predicted_q [$];
  table_result_t    oldest;

  initial fail_count_o = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h want %h", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic table_result_t apply_request(logic [2:0] kind,
                                                  pklt_pkg::entry_t req,
                                                  logic [3:0] sel);
    table_result_t res;
    logic [4:0]    hit;
    logic [4:0]    prev;
    logic [4:0]    cur;
    logic          show;
    res  = '0;
    hit  = NIL;
    show = 1'b0;
    case (kind) inside
      pklt_pkg::KIND_ADD: begin
        if (free_head != NIL) begin
          hit             = free_head;
          free_head       = next_link[hit];
          pool_entry[hit] = req;
          next_link[hit]  = active_head;
          active_head     = hit;
        end
      end
      pklt_pkg::KIND_REM_KEY, pklt_pkg::KIND_REM_SLOT: begin
        prev = NIL;
        cur  = active_head;
        for (int step = 0; step < ENTRIES && cur != NIL && hit == NIL; step++) begin
          if ((kind == pklt_pkg::KIND_REM_KEY) ? (pool_entry[cur].key == req.key)
                                               : (cur == {1'b0, sel})) begin
            hit = cur;
          end else begin
            prev = cur;
            cur  = next_link[cur];
          end
        end
        if (hit != NIL) begin
          if (prev != NIL) next_link[prev] = next_link[hit];
          else active_head = next_link[hit];
          next_link[hit] = free_head;
          free_head      = hit;
        end
      end
      pklt_pkg::KIND_LOOKUP: begin
        show = 1'b1;
        cur  = active_head;
        for (int step = 0; step < ENTRIES && cur != NIL && hit == NIL; step++) begin
          if (pool_entry[cur].key == req.key) hit = cur;
          else cur = next_link[cur];
        end
      end
      pklt_pkg::KIND_NEWEST: begin
        show = 1'b1;
        hit  = active_head;
      end
      default: ;
    endcase
    if (hit != NIL) begin
      res.ok   = 1'b1;
      res.slot = hit[3:0];
      if (show) res.found = pool_entry[hit];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) next_link[i] = 5'(i + 1);
      active_head = NIL;
      free_head   = '0;
      predicted_q.delete();
      pending_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i)
        predicted_q.push_back(apply_request(kind_i,
          '{key: key_addr_i, length: length_i, result: result_code_i,
            channel: channel_or_samples_i, tick: tick_stamp_i}, slot_sel_i));
      if (out_valid_i && out_ready_i) begin
        if (predicted_q.size() == 0) begin
          report_mismatch("result beat with no request pending", '0, '0);
        end else begin
          oldest = predicted_q.pop_front();
          if (ok_i !== oldest.ok) report_mismatch("ok", 32'(ok_i), 32'(oldest.ok));
          if (slot_i !== oldest.slot)
            report_mismatch("slot", 32'(slot_i), 32'(oldest.slot));
          if (found_addr_i !== oldest.found.key)
            report_mismatch("found_addr", found_addr_i, oldest.found.key);
          if (found_length_i !== oldest.found.length)
            report_mismatch("found_length", found_length_i, oldest.found.length);
          if (found_result_i !== oldest.found.result)
            report_mismatch("found_result", found_result_i, oldest.found.result);
          if (found_channel_i !== oldest.found.channel)
            report_mismatch("found_channel", found_channel_i, oldest.found.channel);
          if (found_tick_i !== oldest.found.tick)
            report_mismatch("found_tick", found_tick_i, oldest.found.tick);
        end
      end
      pending_o = predicted_q.size();
    end
  end

endmodule

// ===== bench/pooled_keyed_list_table_unit_test.sv =====
// Testbench top for the pooled keyed list table: drives request beats, paces the
// result channel and prints the verdict. Depends on pklt_pkg, the unit and
// pklt_result_checker.
module pooled_keyed_list_table_unit_test;

  localparam logic [2:0] KIND_RSVD5 = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         kind_i;
  logic [31:0]        key_addr_i;
  logic [31:0]        length_i;
  logic signed [31:0] result_code_i;
  logic signed [31:0] channel_or_samples_i;
  logic [31:0]        tick_stamp_i;
  logic [3:0]         slot_sel_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               ok_o;
  logic [3:0]         slot_o;
  logic [31:0]        found_addr_o;
  logic [31:0]        found_length_o;
  logic signed [31:0] found_result_o;
  logic signed [31:0] found_channel_o;
  logic [31:0]        found_tick_o;

  int fail_count;
  int pending;
  bit tx_no_idle;
  bit rx_no_idle;
  int rx_hold;

  pooled_keyed_list_table_unit dut (.*);

  pklt_result_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .kind_i, .key_addr_i, .length_i, .result_code_i, .channel_or_samples_i,
    .tick_stamp_i, .slot_sel_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .ok_i(ok_o), .slot_i(slot_o),
    .found_addr_i(found_addr_o), .found_length_i(found_length_o),
    .found_result_i(found_result_o), .found_channel_i(found_channel_o),
    .found_tick_i(found_tick_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #2000000;
    $display("pooled_keyed_list_table_unit test failed");
    $finish;
  end

  task automatic send_request(logic [2:0] kind, logic [31:0] key, logic [31:0] len,
                              logic signed [31:0] res, logic signed [31:0] chan,
                              logic [31:0] tick, logic [3:0] sel);
    int gap;
    @(negedge clk_i);
    kind_i               <= kind;
    key_addr_i           <= key;
    length_i             <= len;
    result_code_i        <= res;
    channel_or_samples_i <= chan;
    tick_stamp_i         <= tick;
    slot_sel_i           <= sel;
    in_valid_i           <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    gap = tx_no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_query(logic [2:0] kind, logic [31:0] key, logic [3:0] sel);
    send_request(kind, key, '0, '0, '0, '0, sel);
  endtask

  // result side: random stall per beat, plus one long hold-off on request
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 11);
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int          pick;
    int          add_pct;
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] key_pool [6];
    rst_ni               = 1'b0;
    in_valid_i           = 1'b0;
    kind_i               = '0;
    key_addr_i           = '0;
    length_i             = '0;
    result_code_i        = '0;
    channel_or_samples_i = '0;
    tick_stamp_i         = '0;
    slot_sel_i           = '0;
    tx_no_idle           = 1'b0;
    rx_no_idle           = 1'b0;
    rx_hold              = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table
    send_query(pklt_pkg::KIND_NEWEST, '0, '0);
    send_query(pklt_pkg::KIND_LOOKUP, '0, '0);
    send_query(pklt_pkg::KIND_REM_KEY, '0, '0);
    send_query(pklt_pkg::KIND_REM_SLOT, '0, 4'd0);
    // extremes, then a duplicate key
    send_request(pklt_pkg::KIND_ADD, 32'h0, 32'h0, 32'sh0, 32'sh0, 32'h0, 4'hF);
    send_request(pklt_pkg::KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 4'h0);
    send_request(pklt_pkg::KIND_ADD, 32'h0, 32'h1234_5678, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'h8000_0001, 4'hA);
    send_query(pklt_pkg::KIND_LOOKUP, 32'h0, '0);
    send_query(pklt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, '0);
    send_query(pklt_pkg::KIND_NEWEST, '0, '0);
    send_query(pklt_pkg::KIND_REM_KEY, 32'h0, '0);
    send_query(pklt_pkg::KIND_LOOKUP, 32'h0, '0);
    send_query(pklt_pkg::KIND_REM_SLOT, 32'hFFFF_FFFF, 4'd1);
    send_query(pklt_pkg::KIND_REM_SLOT, '0, 4'd1);
    send_query(pklt_pkg::KIND_LOOKUP, 32'hDEAD_BEEF, '0);
    send_request(KIND_RSVD5, '1, '1, '1, '1, '1, '1);
    send_request(KIND_RSVD6, 32'h5A5A_A5A5, '1, '0, '1, '0, 4'h5);
    send_request(KIND_RSVD7, '1, '0, '1, '0, '1, 4'hA);
    send_query(pklt_pkg::KIND_REM_SLOT, '0, 4'd0);
    send_query(pklt_pkg::KIND_NEWEST, '0, '0);

    // random phases: balanced, filling, draining; keys mostly from a small pool
    for (int phase = 0; phase < PHASES; phase++) begin
      add_pct    = (phase % 3 == 0) ? 35 : (phase % 3 == 1) ? 75 : 10;
      tx_no_idle = (phase == 3 || phase == 6);
      rx_no_idle = (phase == 3 || phase == 7);
      if (phase == 4) rx_hold = HOLD_CYCLES;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
          kind = pklt_pkg::KIND_ADD;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 30) kind = pklt_pkg::KIND_REM_KEY;
          else if (pick < 50) kind = pklt_pkg::KIND_REM_SLOT;
          else if (pick < 72) kind = pklt_pkg::KIND_LOOKUP;
          else if (pick < 90) kind = pklt_pkg::KIND_NEWEST;
          else kind = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
        end
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 5)] : $urandom;
        send_request(kind, key, $urandom, $urandom, $urandom, $urandom,
                     4'($urandom_range(0, 15)));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("pooled_keyed_list_table_unit test passed");
    else
      $display("pooled_keyed_list_table_unit test failed");
    $finish;
  end

endmodule
